// ----- rtl/core/btpf_pkg.sv -----
package btpf_pkg;

  localparam int NODE_CAPACITY_DEF = 1024;
  localparam int FANOUT = 256;
  localparam int BYTE_W = 8;
  localparam int MAXN_W = 11;
  localparam int CNT_W = 11;
  localparam logic [MAXN_W-1:0] MAXN_RST = 11'd1024;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] QS_OPEN = 2'd0;
  localparam logic [1:0] QS_MISS = 2'd1;
  localparam logic [1:0] QS_HIT  = 2'd2;

  localparam logic [4:0] OP_NOP        = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_APPEND     = 5'd2;
  localparam logic [4:0] OP_CLEAR      = 5'd3;
  localparam logic [4:0] OP_SWEEP_ROOT = 5'd4;
  localparam logic [4:0] OP_Q_RD       = 5'd5;
  localparam logic [4:0] OP_Q_MK       = 5'd6;
  localparam logic [4:0] OP_Q_EV       = 5'd7;
  localparam logic [4:0] OP_C_INIT     = 5'd8;
  localparam logic [4:0] OP_C_PRD      = 5'd9;
  localparam logic [4:0] OP_C_LRD      = 5'd10;
  localparam logic [4:0] OP_C_STEP     = 5'd11;
  localparam logic [4:0] OP_C_PUSH     = 5'd12;
  localparam logic [4:0] OP_P_POP      = 5'd13;
  localparam logic [4:0] OP_P_LD       = 5'd14;
  localparam logic [4:0] OP_P_RD       = 5'd15;
  localparam logic [4:0] OP_P_WR       = 5'd16;
  localparam logic [4:0] OP_P_FREE     = 5'd17;
  localparam logic [4:0] OP_B_NEW      = 5'd18;
  localparam logic [4:0] OP_B_FREAD    = 5'd19;
  localparam logic [4:0] OP_B_FTAKE    = 5'd20;
  localparam logic [4:0] OP_B_LINK     = 5'd21;
  localparam logic [4:0] OP_B_SWEEP    = 5'd22;
  localparam logic [4:0] OP_POST       = 5'd23;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] code;
  } btpf_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       byte_zero;
    logic       add_seen;
    logic       q_open;
    logic       out_free;
    logic       top_done;
    logic       node_marked;
    logic       link_zero;
    logic       over_budget;
    logic       last;
    logic       fresh;
    logic       pstk_empty;
    logic       b_last;
  } btpf_stat_t;

endpackage

// ----- rtl/core/btpf_ram.sv -----
module btpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/btpf_ctrl.sv -----
module btpf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  btpf_pkg::btpf_stat_t stat,
  output btpf_pkg::btpf_cmd_t  cmd
);
  import btpf_pkg::*;

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_Q_MK    = 5'd3;
  localparam logic [4:0] S_Q_EV    = 5'd4;
  localparam logic [4:0] S_C_TOP   = 5'd5;
  localparam logic [4:0] S_C_PB    = 5'd6;
  localparam logic [4:0] S_C_EV    = 5'd7;
  localparam logic [4:0] S_B_ALLOC = 5'd8;
  localparam logic [4:0] S_B_FTAKE = 5'd9;
  localparam logic [4:0] S_B_LINK  = 5'd10;
  localparam logic [4:0] S_B_SWEEP = 5'd11;
  localparam logic [4:0] S_B_PRD   = 5'd12;
  localparam logic [4:0] S_B_PB    = 5'd13;
  localparam logic [4:0] S_P_POP   = 5'd14;
  localparam logic [4:0] S_P_LD    = 5'd15;
  localparam logic [4:0] S_P_RD    = 5'd16;
  localparam logic [4:0] S_P_WR    = 5'd17;
  localparam logic [4:0] S_P_FREE  = 5'd18;
  localparam logic [4:0] S_POST    = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic [1:0] code_r, code_nxt;
  logic       post_init_r, post_init_nxt;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    post_init_nxt = post_init_r;
    cmd.op        = OP_NOP;
    cmd.code      = code_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_SWEEP_ROOT;
        if (stat.b_last) begin
          code_nxt  = ST_OK;
          state_nxt = post_init_r ? S_POST : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        if (stat.kind == KIND_ADD) begin
          if (!stat.byte_zero) begin
            cmd.op = OP_APPEND;
          end else if (stat.add_seen) begin
            cmd.op    = OP_C_INIT;
            state_nxt = S_C_TOP;
          end else begin
            code_nxt  = ST_EMPTY;
            state_nxt = S_POST;
          end
        end else if (stat.kind == KIND_QUERY) begin
          if (!stat.byte_zero) begin
            if (stat.q_open) begin
              cmd.op    = OP_Q_RD;
              state_nxt = S_Q_MK;
            end
          end else begin
            code_nxt  = ST_OK;
            state_nxt = S_POST;
          end
        end else if (stat.kind == KIND_CLEAR) begin
          cmd.op        = OP_CLEAR;
          post_init_nxt = 1'b1;
          state_nxt     = S_INIT;
        end
      end
      S_Q_MK: begin
        cmd.op    = OP_Q_MK;
        state_nxt = S_Q_EV;
      end
      S_Q_EV: begin
        cmd.op    = OP_Q_EV;
        state_nxt = S_IDLE;
      end
      S_C_TOP: begin
        if (stat.top_done) begin
          code_nxt  = ST_OK;
          state_nxt = S_POST;
        end else begin
          cmd.op    = OP_C_PRD;
          state_nxt = S_C_PB;
        end
      end
      S_C_PB: begin
        cmd.op    = OP_C_LRD;
        state_nxt = S_C_EV;
      end
      S_C_EV: begin
        priority if (stat.node_marked) begin
          code_nxt  = ST_OK;
          state_nxt = S_POST;
        end else if (stat.link_zero) begin
          if (stat.over_budget) begin
            code_nxt  = ST_FULL;
            state_nxt = S_POST;
          end else begin
            state_nxt = S_B_ALLOC;
          end
        end else if (stat.last) begin
          cmd.op    = OP_C_PUSH;
          state_nxt = S_P_POP;
        end else begin
          cmd.op    = OP_C_STEP;
          state_nxt = S_C_TOP;
        end
      end
      S_B_ALLOC: begin
        if (stat.fresh) begin
          cmd.op    = OP_B_NEW;
          state_nxt = S_B_LINK;
        end else begin
          cmd.op    = OP_B_FREAD;
          state_nxt = S_B_FTAKE;
        end
      end
      S_B_FTAKE: begin
        cmd.op    = OP_B_FTAKE;
        state_nxt = S_B_LINK;
      end
      S_B_LINK: begin
        cmd.op    = OP_B_LINK;
        state_nxt = S_B_SWEEP;
      end
      S_B_SWEEP: begin
        cmd.op = OP_B_SWEEP;
        if (stat.b_last) begin
          if (stat.last) begin
            code_nxt  = ST_OK;
            state_nxt = S_POST;
          end else begin
            state_nxt = S_B_PRD;
          end
        end
      end
      S_B_PRD: begin
        cmd.op    = OP_C_PRD;
        state_nxt = S_B_PB;
      end
      S_B_PB: begin
        cmd.op    = OP_C_LRD;
        state_nxt = S_B_ALLOC;
      end
      S_P_POP: begin
        if (stat.pstk_empty) begin
          state_nxt = S_B_ALLOC;
        end else begin
          cmd.op    = OP_P_POP;
          state_nxt = S_P_LD;
        end
      end
      S_P_LD: begin
        cmd.op    = OP_P_LD;
        state_nxt = S_P_RD;
      end
      S_P_RD: begin
        cmd.op    = OP_P_RD;
        state_nxt = S_P_WR;
      end
      S_P_WR: begin
        cmd.op    = OP_P_WR;
        state_nxt = stat.b_last ? S_P_FREE : S_P_RD;
      end
      S_P_FREE: begin
        cmd.op    = OP_P_FREE;
        state_nxt = S_P_POP;
      end
      S_POST: begin
        if (stat.out_free) begin
          cmd.op        = OP_POST;
          post_init_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      code_r      <= ST_OK;
      post_init_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      post_init_r <= post_init_nxt;
    end
  end

endmodule

// ----- rtl/core/btpf_dp.sv -----
module btpf_dp #(
  parameter int NODE_CAPACITY = btpf_pkg::NODE_CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  btpf_pkg::btpf_cmd_t          cmd,
  output btpf_pkg::btpf_stat_t         stat,
  input  logic [1:0]                   in_kind,
  input  logic [btpf_pkg::BYTE_W-1:0]  in_char_byte,
  input  logic                         cfg_wr_en,
  input  logic [btpf_pkg::MAXN_W-1:0]  cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_done_kind,
  output logic [1:0]                   out_status,
  output logic                         out_matched,
  output logic [btpf_pkg::CNT_W-1:0]   out_nodes_used
);
  import btpf_pkg::*;

  localparam int NW = $clog2(NODE_CAPACITY + 1);
  localparam int FW = $clog2(NODE_CAPACITY);
  localparam int LW = (NW > MAXN_W) ? NW : MAXN_W;
  localparam int LINK_DEPTH = (NODE_CAPACITY + 1) * FANOUT;
  localparam int LAW = $clog2(LINK_DEPTH);
  localparam logic [NW-1:0] CAP_V = NW'(NODE_CAPACITY);

  logic [1:0]        kind_r, kind_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [MAXN_W-1:0] maxn_r, maxn_nxt;
  logic [NW-1:0]     used_r, used_nxt;
  logic [NW-1:0]     hw_r, hw_nxt;
  logic [NW-1:0]     plen_r, plen_nxt;
  logic              add_seen_r, add_seen_nxt;
  logic [NW-1:0]     walk_r, walk_nxt;
  logic [1:0]        qs_r, qs_nxt;
  logic [BYTE_W-1:0] b_r, b_nxt;
  logic [NW-1:0]     node_r, node_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NW-1:0]     pn_r, pn_nxt;
  logic [NW-1:0]     len_r, len_nxt;
  logic [NW-1:0]     i_r, i_nxt;
  logic [NW-1:0]     c_r, c_nxt;
  logic [BYTE_W-1:0] pb_r, pb_nxt;
  logic [NW:0]       pcnt_r, pcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_matched_r, out_matched_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic [LW-1:0]     lim;
  logic              last;

  logic              link_we;
  logic [LAW-1:0]    link_waddr, link_raddr;
  logic [NW-1:0]     link_wdata, link_rdata;
  logic              mark_we;
  logic [NW-1:0]     mark_waddr, mark_raddr;
  logic [0:0]        mark_wdata, mark_rdata;
  logic              pend_we;
  logic [FW-1:0]     pend_waddr, pend_raddr;
  logic [BYTE_W-1:0] pend_rdata;
  logic              free_we;
  logic [FW-1:0]     free_waddr, free_raddr;
  logic [NW-1:0]     free_rdata;
  logic              pstk_we;
  logic [NW-1:0]     pstk_waddr, pstk_raddr;
  logic [NW-1:0]     pstk_rdata;

  assign lim  = (LW'(maxn_r) < LW'(CAP_V)) ? LW'(maxn_r) : LW'(CAP_V);
  assign last = ((NW + 1)'(i_r) + (NW + 1)'(1)) == (NW + 1)'(len_r);

  always_comb begin
    stat.kind        = kind_r;
    stat.byte_zero   = (byte_r == '0);
    stat.add_seen    = add_seen_r;
    stat.q_open      = (qs_r == QS_OPEN);
    stat.out_free    = !out_valid_r || out_ready;
    stat.top_done    = (i_r >= len_r);
    stat.node_marked = (node_r != '0) && mark_rdata[0];
    stat.link_zero   = (link_rdata == '0);
    stat.over_budget = ((LW + 1)'(used_r) + (LW + 1)'(len_r - i_r)) > (LW + 1)'(lim);
    stat.last        = last;
    stat.fresh       = (used_r == hw_r);
    stat.pstk_empty  = (pcnt_r == '0);
    stat.b_last      = (b_r == '1);
  end

  always_comb begin
    kind_nxt        = kind_r;
    byte_nxt        = byte_r;
    maxn_nxt        = cfg_wr_en ? cfg_wr_data : maxn_r;
    used_nxt        = used_r;
    hw_nxt          = hw_r;
    plen_nxt        = plen_r;
    add_seen_nxt    = add_seen_r;
    walk_nxt        = walk_r;
    qs_nxt          = qs_r;
    b_nxt           = b_r;
    node_nxt        = node_r;
    n_nxt           = n_r;
    pn_nxt          = pn_r;
    len_nxt         = len_r;
    i_nxt           = i_r;
    c_nxt           = c_r;
    pb_nxt          = pb_r;
    pcnt_nxt        = pcnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_matched_nxt = out_matched_r;
    out_count_nxt   = out_count_r;

    link_we    = 1'b0;
    link_waddr = LAW'({node_r, pb_r});
    link_wdata = '0;
    link_raddr = LAW'({walk_r, byte_r});
    mark_we    = 1'b0;
    mark_waddr = n_r;
    mark_wdata = 1'b0;
    mark_raddr = node_r;
    pend_we    = 1'b0;
    pend_waddr = FW'(plen_r);
    pend_raddr = FW'(i_r);
    free_we    = 1'b0;
    free_waddr = FW'(CAP_V - used_r);
    free_raddr = FW'(CAP_V - NW'(1) - used_r);
    pstk_we    = 1'b0;
    pstk_waddr = NW'(pcnt_r);
    pstk_raddr = NW'(pcnt_r - (NW + 1)'(1));

    unique case (cmd.op)
      OP_LOAD: begin
        kind_nxt = in_kind;
        byte_nxt = in_char_byte;
      end
      OP_APPEND: begin
        add_seen_nxt = 1'b1;
        if ((LW'(plen_r) < lim) && (plen_r < CAP_V)) begin
          pend_we  = 1'b1;
          plen_nxt = plen_r + NW'(1);
        end
      end
      OP_CLEAR: begin
        used_nxt     = '0;
        hw_nxt       = '0;
        plen_nxt     = '0;
        add_seen_nxt = 1'b0;
        walk_nxt     = '0;
        qs_nxt       = QS_OPEN;
        b_nxt        = '0;
      end
      OP_SWEEP_ROOT: begin
        link_we    = 1'b1;
        link_waddr = LAW'({NW'(0), b_r});
        b_nxt      = b_r + BYTE_W'(1);
      end
      OP_Q_RD: begin
        link_raddr = LAW'({walk_r, byte_r});
      end
      OP_Q_MK: begin
        c_nxt      = link_rdata;
        mark_raddr = link_rdata;
      end
      OP_Q_EV: begin
        if (c_r == '0) begin
          qs_nxt = QS_MISS;
        end else if (mark_rdata[0]) begin
          qs_nxt = QS_HIT;
        end else begin
          walk_nxt = c_r;
        end
      end
      OP_C_INIT: begin
        len_nxt  = (LW'(plen_r) < lim) ? plen_r : NW'(lim);
        node_nxt = '0;
        i_nxt    = '0;
      end
      OP_C_PRD: begin
        pend_raddr = FW'(i_r);
      end
      OP_C_LRD: begin
        pb_nxt     = pend_rdata;
        link_raddr = LAW'({node_r, pend_rdata});
        mark_raddr = node_r;
      end
      OP_C_STEP: begin
        node_nxt = link_rdata;
        i_nxt    = i_r + NW'(1);
      end
      OP_C_PUSH: begin
        pstk_we    = 1'b1;
        pstk_waddr = '0;
        pcnt_nxt   = (NW + 1)'(1);
      end
      OP_P_POP: begin
        pcnt_nxt = pcnt_r - (NW + 1)'(1);
      end
      OP_P_LD: begin
        pn_nxt = pstk_rdata;
        b_nxt  = '0;
      end
      OP_P_RD: begin
        link_raddr = LAW'({pn_r, b_r});
      end
      OP_P_WR: begin
        link_we    = 1'b1;
        link_waddr = LAW'({pn_r, b_r});
        if (link_rdata != '0) begin
          pstk_we  = 1'b1;
          pcnt_nxt = pcnt_r + (NW + 1)'(1);
        end
        b_nxt = b_r + BYTE_W'(1);
      end
      OP_P_FREE: begin
        mark_we    = 1'b1;
        mark_waddr = pn_r;
        free_we    = 1'b1;
        used_nxt   = used_r - NW'(1);
      end
      OP_B_NEW: begin
        n_nxt    = used_r + NW'(1);
        hw_nxt   = hw_r + NW'(1);
        used_nxt = used_r + NW'(1);
      end
      OP_B_FREAD: begin
        free_raddr = FW'(CAP_V - NW'(1) - used_r);
      end
      OP_B_FTAKE: begin
        n_nxt    = free_rdata;
        used_nxt = used_r + NW'(1);
      end
      OP_B_LINK: begin
        link_we    = 1'b1;
        link_waddr = LAW'({node_r, pb_r});
        link_wdata = n_r;
        mark_we    = 1'b1;
        mark_waddr = n_r;
        mark_wdata = last;
        b_nxt      = '0;
      end
      OP_B_SWEEP: begin
        link_we    = 1'b1;
        link_waddr = LAW'({n_r, b_r});
        b_nxt      = b_r + BYTE_W'(1);
        if (b_r == '1) begin
          node_nxt = n_r;
          i_nxt    = i_r + NW'(1);
        end
      end
      OP_POST: begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = kind_r;
        out_status_nxt  = cmd.code;
        out_matched_nxt = (kind_r == KIND_QUERY) && (qs_r == QS_HIT);
        out_count_nxt   = CNT_W'(LW'(used_r));
        if (kind_r == KIND_ADD) begin
          plen_nxt     = '0;
          add_seen_nxt = 1'b0;
        end
        if (kind_r == KIND_QUERY) begin
          walk_nxt = '0;
          qs_nxt   = QS_OPEN;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxn_r      <= MAXN_RST;
      used_r      <= '0;
      hw_r        <= '0;
      plen_r      <= '0;
      add_seen_r  <= 1'b0;
      walk_r      <= '0;
      qs_r        <= QS_OPEN;
      b_r         <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      maxn_r      <= maxn_nxt;
      used_r      <= used_nxt;
      hw_r        <= hw_nxt;
      plen_r      <= plen_nxt;
      add_seen_r  <= add_seen_nxt;
      walk_r      <= walk_nxt;
      qs_r        <= qs_nxt;
      b_r         <= b_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    byte_r        <= byte_nxt;
    node_r        <= node_nxt;
    n_r           <= n_nxt;
    pn_r          <= pn_nxt;
    len_r         <= len_nxt;
    i_r           <= i_nxt;
    c_r           <= c_nxt;
    pb_r          <= pb_nxt;
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_matched_r <= out_matched_nxt;
    out_count_r   <= out_count_nxt;
  end

  btpf_ram #(.WIDTH(NW), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  btpf_ram #(.WIDTH(1), .DEPTH(NODE_CAPACITY + 1)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  btpf_ram #(.WIDTH(BYTE_W), .DEPTH(NODE_CAPACITY)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (byte_r),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  btpf_ram #(.WIDTH(NW), .DEPTH(NODE_CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (pn_r),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  btpf_ram #(.WIDTH(NW), .DEPTH(NODE_CAPACITY + 1)) u_pstk_ram (
    .clk   (clk),
    .we    (pstk_we),
    .waddr (pstk_waddr),
    .wdata (link_rdata),
    .raddr (pstk_raddr),
    .rdata (pstk_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_done_kind  = out_kind_r;
  assign out_status     = out_status_r;
  assign out_matched    = out_matched_r;
  assign out_nodes_used = out_count_r;

`ifndef SYNTHESIS
  a_hw_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r >= used_r)
    else $error("allocation high-water mark fell below the node count");
  a_post_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_POST) |-> (!out_valid_r || out_ready))
    else $error("result posted over an item not yet taken");
  a_free_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_P_FREE) |-> (used_r != '0))
    else $error("node freed with no nodes in use");
  a_new_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_B_NEW) |=> (used_r <= CAP_V) && (n_r != '0))
    else $error("fresh node allocated beyond the pool");
`endif

endmodule

// ----- rtl/core/byte_trie_prefix_filter_top.sv -----
// Byte trie prefix filter. Strings arrive one byte per item and end with a zero byte; a result
// item comes out at each string terminator and at each clear, and the next item may be accepted
// while a result waits in the output register. A query byte whose walk is still open passes
// through further states for the registered reads of the child-link and prefix-mark memories.
// An add terminator walks the buffered string, then clears the 256 child links of each new
// node through the single write port of the link memory; replacing an existing subtree clears
// the links of every node freed. A clear, and the start after reset, clear the root's 256
// links, during which no item is accepted; configuration writes are taken at any time.
module byte_trie_prefix_filter_top #(
  parameter int NODE_CAPACITY = btpf_pkg::NODE_CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic [btpf_pkg::BYTE_W-1:0]  in_char_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_done_kind,
  output logic [1:0]                   out_status,
  output logic                         out_matched,
  output logic [btpf_pkg::CNT_W-1:0]   out_nodes_used,
  input  logic                         cfg_wr_en,
  input  logic [btpf_pkg::MAXN_W-1:0]  cfg_wr_data
);
  import btpf_pkg::*;

  btpf_cmd_t  cmd;
  btpf_stat_t stat;

  btpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  btpf_dp #(.NODE_CAPACITY(NODE_CAPACITY)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_char_byte   (in_char_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_done_kind  (out_done_kind),
    .out_status     (out_status),
    .out_matched    (out_matched),
    .out_nodes_used (out_nodes_used)
  );

endmodule

// ----- sim/btpf_checker.sv -----
module btpf_checker
  import btpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [BYTE_W-1:0] in_char_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_done_kind,
  input  logic [1:0]        out_status,
  input  logic              out_matched,
  input  logic [CNT_W-1:0]  out_nodes_used,
  input  logic              cfg_wr_en,
  input  logic [MAXN_W-1:0] cfg_wr_data,
  output int                fail_count,
  output int                pending
);

  localparam int CAP = NODE_CAPACITY_DEF;
  localparam int unsigned ROOT = 0;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic             matched;
    logic [CNT_W-1:0] count;
  } trie_result_t;

  int unsigned links[(CAP+1)*FANOUT];
  bit marks[CAP+1];
  int unsigned pool[CAP];
  int unsigned stk[CAP+1];
  logic [BYTE_W-1:0] pend_bytes[CAP];
  int unsigned used, plen, walk;
  bit seen, rst_done;
  logic [1:0] qstate;
  logic [MAXN_W-1:0] budget;
  trie_result_t expected_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
    rst_done = 0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic int unsigned lim_now();
    return (budget < CAP) ? budget : CAP;
  endfunction

  function automatic int unsigned link_idx(int unsigned node, int unsigned b);
    return (node % (CAP+1)) * FANOUT + (b & 8'hFF);
  endfunction

  function automatic int unsigned take_node();
    int unsigned n;
    if (used >= CAP) return ROOT;
    n = pool[CAP-used-1];
    used++;
    return n;
  endfunction

  function automatic void give_node(int unsigned n);
    if (used == 0) return;
    used--;
    pool[CAP-used-1] = n;
  endfunction

  function automatic void drop_subtree(int unsigned target);
    int unsigned cnt, n, c;
    if (target == ROOT || target > CAP) return;
    cnt = 0;
    stk[cnt] = target;
    cnt++;
    while (cnt != 0) begin
      cnt--;
      n = stk[cnt];
      for (int b = 0; b < FANOUT; b++) begin
        c = links[link_idx(n, b)];
        if (c != ROOT && c <= CAP && cnt < CAP+1) begin
          stk[cnt] = c;
          cnt++;
        end
        links[link_idx(n, b)] = ROOT;
      end
      marks[n] = 0;
      give_node(n);
    end
  endfunction

  function automatic void wipe_trie();
    foreach (links[k]) links[k] = ROOT;
    foreach (marks[k]) marks[k] = 0;
    for (int k = 0; k < CAP; k++) pool[k] = CAP - k;
    used = 0;
    plen = 0;
    seen = 0;
    walk = ROOT;
    qstate = QS_OPEN;
  endfunction

  function automatic logic [1:0] insert_prefix();
    int unsigned lim, len, node, i, c, n;
    lim = lim_now();
    len = (plen < lim) ? plen : lim;
    node = ROOT;
    i = 0;
    while (i < len) begin
      if (marks[node]) break;
      c = links[link_idx(node, pend_bytes[i])];
      if (c == ROOT) begin
        if (used + (len - i) > lim) return ST_FULL;
        while (i < len) begin
          n = take_node();
          if (n == ROOT) return ST_FULL;
          links[link_idx(node, pend_bytes[i])] = n;
          node = n;
          i++;
        end
        marks[node] = 1;
        break;
      end else if (i + 1 == len) begin
        drop_subtree(c);
        n = take_node();
        if (n == ROOT) return ST_FULL;
        marks[n] = 1;
        links[link_idx(node, pend_bytes[i])] = n;
        break;
      end
      node = c;
      i++;
    end
    return ST_OK;
  endfunction

  task automatic predict_item(input logic [1:0] kind, input logic [BYTE_W-1:0] b);
    trie_result_t r;
    int unsigned c;
    r = '0;
    r.kind = kind;
    if (kind == KIND_ADD) begin
      if (b != 0) begin
        seen = 1;
        if (plen < lim_now() && plen < CAP) begin
          pend_bytes[plen] = b;
          plen++;
        end
        return;
      end
      r.status = seen ? insert_prefix() : ST_EMPTY;
      plen = 0;
      seen = 0;
    end else if (kind == KIND_QUERY) begin
      if (b != 0) begin
        if (qstate == QS_OPEN) begin
          c = links[link_idx(walk, b)];
          if (c == ROOT || c > CAP) qstate = QS_MISS;
          else if (marks[c]) qstate = QS_HIT;
          else walk = c;
        end
        return;
      end
      r.matched = (qstate == QS_HIT);
      walk = ROOT;
      qstate = QS_OPEN;
    end else if (kind == KIND_CLEAR) begin
      wipe_trie();
    end else begin
      return;
    end
    r.count = used[CNT_W-1:0];
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    trie_result_t w;
    if (!rst_n) begin
      if (!rst_done) begin
        wipe_trie();
        budget = MAXN_RST;
        rst_done = 1;
      end
    end else begin
      if (cfg_wr_en) budget = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result item, kind %0d", out_done_kind);
          fail_count++;
        end else begin
          w = expected_q.pop_front();
          if (out_done_kind !== w.kind) report("done_kind", out_done_kind, w.kind);
          if (out_status !== w.status) report("status", out_status, w.status);
          if (out_matched !== w.matched) report("matched", out_matched, w.matched);
          if (out_nodes_used !== w.count) report("nodes_used", out_nodes_used, w.count);
        end
      end
      if (in_valid && in_ready) predict_item(in_kind, in_char_byte);
    end
    pending = expected_q.size();
  end

endmodule

// ----- sim/byte_trie_prefix_filter_top_tb.sv -----
module byte_trie_prefix_filter_top_tb;
  import btpf_pkg::*;

  localparam int ITEM_GOAL = 1450;
  localparam int STALL_LIMIT = 3000000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_kind = KIND_ADD;
  logic [BYTE_W-1:0] in_char_byte = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_done_kind;
  logic [1:0] out_status;
  logic out_matched;
  logic [CNT_W-1:0] out_nodes_used;
  logic cfg_wr_en = 0;
  logic [MAXN_W-1:0] cfg_wr_data = '0;

  int fail_count, pending;
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 0;
  bit hold_go = 0;
  bit hold_done = 0;

  byte_trie_prefix_filter_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_char_byte(in_char_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_done_kind(out_done_kind), .out_status(out_status),
    .out_matched(out_matched), .out_nodes_used(out_nodes_used),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  btpf_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_char_byte(in_char_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_done_kind(out_done_kind), .out_status(out_status),
    .out_matched(out_matched), .out_nodes_used(out_nodes_used),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      rdy = 0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1;
      stall_left = 400;
      rdy = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      rdy = 0;
    end else begin
      rdy = 1;
    end
    out_ready <= rdy;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(input logic [1:0] kind, input logic [BYTE_W-1:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_char_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (kind != KIND_NONE) items_sent++;
  endtask

  task automatic send_str(input logic [1:0] kind, input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send(kind, BYTE_W'($urandom_range(1, 255)));
      else send(kind, BYTE_W'((i == 0) ? $urandom_range(1, 3) : $urandom_range(1, 4)));
    end
    send(kind, 0);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_budget(input logic [MAXN_W-1:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_phase(input int count);
    int stop, r, len;
    stop = items_sent + count;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
      if ($urandom_range(0, 29) == 0) len = 0;
      if (r < 44) begin
        send_str(KIND_ADD, len);
      end else if (r < 88) begin
        send_str(KIND_QUERY, len);
      end else if (r < 92) begin
        send(KIND_CLEAR, BYTE_W'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send(KIND_NONE, BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3))
          send($urandom_range(0, 1) ? KIND_ADD : KIND_QUERY, BYTE_W'($urandom_range(1, 255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(KIND_ADD, 0);
    send(KIND_QUERY, 0);
    send(KIND_ADD, 1); send(KIND_ADD, 2); send(KIND_ADD, 0);
    send(KIND_QUERY, 1); send(KIND_QUERY, 2); send(KIND_QUERY, 3); send(KIND_QUERY, 0);
    send(KIND_QUERY, 1); send(KIND_QUERY, 0);
    send(KIND_ADD, 1); send(KIND_ADD, 2); send(KIND_ADD, 5); send(KIND_ADD, 0);
    send(KIND_ADD, 1); send(KIND_ADD, 0);
    send(KIND_QUERY, 255);
    send(KIND_ADD, 255); send(KIND_ADD, 128); send(KIND_ADD, 0);
    send(KIND_QUERY, 2);
    send(KIND_ADD, 2); send(KIND_ADD, 0);
    send(KIND_QUERY, 0);
    send(KIND_NONE, 8'hAA);
    send(KIND_CLEAR, 8'hFF);

    set_budget(3);
    for (int i = 1; i <= 6; i++) send(KIND_ADD, BYTE_W'(i));
    send(KIND_ADD, 0);
    send(KIND_ADD, 9); send(KIND_ADD, 9); send(KIND_ADD, 9); send(KIND_ADD, 0);
    hold_go = 1;
    random_phase(200);

    set_budget(0);
    send(KIND_ADD, 7); send(KIND_ADD, 0);
    random_phase(120);

    set_budget(1);
    random_phase(200);
    drain();

    set_budget(11'd2047);
    random_phase(300);

    set_budget(12);
    random_phase(250);

    set_budget(MAXN_RST);
    quiet = 1;
    while (items_sent < ITEM_GOAL) random_phase(50);

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/btpf_pkg.sv
rtl/core/btpf_ram.sv
rtl/core/btpf_ctrl.sv
rtl/core/btpf_dp.sv
rtl/core/byte_trie_prefix_filter_top.sv
sim/btpf_checker.sv
sim/byte_trie_prefix_filter_top_tb.sv
